FILE: design/c6502_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_pkg: shared types and constants of the 6502 execute unit
// Operation codes, request and result payloads, flag positions.
// ----------------------------------------------------------------------------
package c6502_pkg;

	typedef enum logic [5:0] {
		OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ORA = 6'd3,
		OP_EOR = 6'd4,  OP_BIT = 6'd5,  OP_CMP = 6'd6,  OP_CPX = 6'd7,
		OP_CPY = 6'd8,  OP_ASL = 6'd9,  OP_LSR = 6'd10, OP_ROL = 6'd11,
		OP_ROR = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14, OP_INX = 6'd15,
		OP_INY = 6'd16, OP_DEX = 6'd17, OP_DEY = 6'd18, OP_LDA = 6'd19,
		OP_LDX = 6'd20, OP_LDY = 6'd21, OP_STA = 6'd22, OP_STX = 6'd23,
		OP_STY = 6'd24, OP_TAX = 6'd25, OP_TAY = 6'd26, OP_TSX = 6'd27,
		OP_TXA = 6'd28, OP_TXS = 6'd29, OP_TYA = 6'd30, OP_CLC = 6'd31,
		OP_CLD = 6'd32, OP_CLI = 6'd33, OP_CLV = 6'd34, OP_SEC = 6'd35,
		OP_SED = 6'd36, OP_SEI = 6'd37, OP_PHA = 6'd38, OP_PHP = 6'd39,
		OP_PLA = 6'd40, OP_PLP = 6'd41, OP_BCC = 6'd42, OP_BCS = 6'd43,
		OP_BEQ = 6'd44, OP_BMI = 6'd45, OP_BNE = 6'd46, OP_BPL = 6'd47,
		OP_BVC = 6'd48, OP_BVS = 6'd49, OP_NOP = 6'd50
	} op_t;

	typedef enum logic [1:0] {
		WK_NONE = 2'd0,
		WK_MEM  = 2'd1,
		WK_PUSH = 2'd2
	} wkind_t;

	localparam int FC = 0;
	localparam int FZ = 1;
	localparam int FI = 2;
	localparam int FD = 3;
	localparam int FB = 4;
	localparam int FU = 5;
	localparam int FV = 6;
	localparam int FN = 7;

	localparam logic [7:0]  SP_RESET = 8'hFD;
	localparam logic [7:0]  P_RESET  = 8'h20;
	localparam logic [15:0] PAGE_MASK = 16'hFF00;
	localparam logic [15:0] STACK_BASE = 16'h0100;
	localparam int          QDEPTH = 2;

	typedef struct packed {
		logic [5:0]  op;
		logic [7:0]  operand;
		logic        to_accumulator;
		logic [15:0] target_address;
		logic [15:0] next_pc;
	} req_t;

	// classified request handed from front to back
	typedef struct packed {
		req_t        req;
		logic        is_branch;
		logic        br_want;
		logic [1:0]  br_flag;   // 0 C, 1 Z, 2 N, 3 V
		logic [15:0] br_target;
		logic        br_cross;
	} cls_t;

	typedef struct packed {
		logic [1:0]  write_kind;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic        branch_taken;
		logic [15:0] branch_target;
		logic [1:0]  extra_cycles;
		logic [7:0]  acc_out;
		logic [7:0]  x_out;
		logic [7:0]  y_out;
		logic [7:0]  sp_out;
		logic [7:0]  status_out;
	} res_t;

endpackage

FILE: design/c6502_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_if: valid/ready channel
// Carries one request or result with its handshake.
// ----------------------------------------------------------------------------
interface c6502_req_if;
	import c6502_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface c6502_res_if;
	import c6502_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/c6502_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_front: request classification
// Decodes branch condition and computes the branch target and page cross.
// ----------------------------------------------------------------------------
module c6502_front (
	input  c6502_pkg::req_t req,
	output c6502_pkg::cls_t cls
);
	import c6502_pkg::*;

	logic [15:0] rel;
	logic [2:0]  k;

	always_comb begin
		rel = {{8{req.operand[7]}}, req.operand};
		k = 3'(req.op - 6'(OP_BCC));
		cls.req = req;
		cls.is_branch = (req.op inside {[OP_BCC:OP_BVS]});
		cls.br_target = req.next_pc + rel;
		cls.br_cross = ((req.next_pc ^ cls.br_target) & PAGE_MASK) != 16'h0;
		cls.br_want = k[0];
		case (k[2:1])
			2'd0: cls.br_flag = 2'd0;
			2'd1: cls.br_flag = k[0] ? 2'd2 : 2'd1;
			2'd2: cls.br_flag = k[0] ? 2'd2 : 2'd1;
			default: cls.br_flag = 2'd3;
		endcase
		// BMI wants N set, BNE wants Z clear, BPL wants N clear
		if (k == 3'd2) cls.br_want = 1'b1;
		if (k == 3'd3) cls.br_want = 1'b1;
		if (k == 3'd4) cls.br_want = 1'b0;
		if (k == 3'd5) cls.br_want = 1'b0;
	end

endmodule

FILE: design/c6502_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_queue: two-entry request queue
// Decouples the front from the back.
// ----------------------------------------------------------------------------
module c6502_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  c6502_pkg::cls_t din,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output c6502_pkg::cls_t dout
);
	import c6502_pkg::*;

	cls_t       mem_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(QDEPTH));
	assign empty = (cnt_q == 2'd0);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: design/c6502_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_back: register file, ALU and result register
// Executes one classified request per cycle while go is asserted, and holds the result.
// ----------------------------------------------------------------------------
module c6502_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  c6502_pkg::cls_t cls,
	output c6502_pkg::res_t res
);
	import c6502_pkg::*;

	logic [7:0] a_q, x_q, y_q, sp_q, p_q;
	logic [7:0] a_n, x_n, y_n, sp_n, p_n;
	res_t       r_n, res_q;
	logic [7:0] m, src, rr, t;
	logic [8:0] bin, cmpv;
	logic [7:0] mi;
	logic [5:0] lo;
	logic [5:0] hi;
	logic signed [6:0] slo;
	logic signed [9:0] sr;
	logic       rmw, c, flag;
	op_t        op;

	assign res = res_q;

	always_comb begin
		op = op_t'(cls.req.op);
		m = cls.req.operand;
		c = p_q[FC];
		src = cls.req.to_accumulator ? a_q : m;
		a_n = a_q; x_n = x_q; y_n = y_q; sp_n = sp_q; p_n = p_q;
		r_n = '0;
		rr = 8'h0; rmw = 1'b0; t = 8'h0;
		mi = ~m;
		bin = 9'h0; cmpv = 9'h0; lo = 6'h0; hi = 6'h0; slo = '0; sr = '0;
		flag = 1'b0;
		case (op)
			OP_ADC: begin
				bin = {1'b0, a_q} + {1'b0, m} + 9'(c);
				p_n[FC] = bin[8];
				p_n[FZ] = bin[7:0] == 8'h0;
				p_n[FN] = bin[7];
				p_n[FV] = (bin[7] ^ a_q[7]) & (bin[7] ^ m[7]);
				a_n = bin[7:0];
				if (p_q[FD]) begin
					r_n.extra_cycles = 2'd1;
					lo = {2'b0, a_q[3:0]} + {2'b0, m[3:0]} + 6'(c);
					if (lo > 6'd9) lo = lo + 6'd6;
					hi = {2'b0, a_q[7:4]} + {2'b0, m[7:4]} + 6'(lo > 6'hF);
					p_n[FN] = hi[3];
					p_n[FV] = ~(a_q[7] ^ m[7]) & (a_q[7] ^ hi[3]);
					if (hi > 6'd9) hi = hi + 6'd6;
					p_n[FC] = hi > 6'hF;
					a_n = {hi[3:0], lo[3:0]};
				end
			end
			OP_SBC: begin
				bin = {1'b0, a_q} + {1'b0, mi} + 9'(c);
				p_n[FC] = bin[8];
				p_n[FZ] = bin[7:0] == 8'h0;
				p_n[FN] = bin[7];
				p_n[FV] = (bin[7] ^ a_q[7]) & (bin[7] ^ mi[7]);
				a_n = bin[7:0];
				if (p_q[FD]) begin
					r_n.extra_cycles = 2'd1;
					slo = 7'(signed'({1'b0, a_q[3:0]})) - 7'(signed'({1'b0, m[3:0]}))
						+ 7'(signed'({1'b0, c})) - 7'sd1;
					if (slo < 0) slo = 7'(signed'({3'b0, 4'(slo + 7'sd26)})) - 7'sd16;
					sr = 10'(signed'({2'b0, a_q[7:4], 4'h0}))
						- 10'(signed'({2'b0, m[7:4], 4'h0})) + 10'(slo);
					if (sr < 0) sr = sr - 10'sd96;
					a_n = sr[7:0];
				end
			end
			OP_AND: begin a_n = a_q & m; p_n[FZ] = a_n == 8'h0; p_n[FN] = a_n[7]; end
			OP_ORA: begin a_n = a_q | m; p_n[FZ] = a_n == 8'h0; p_n[FN] = a_n[7]; end
			OP_EOR: begin a_n = a_q ^ m; p_n[FZ] = a_n == 8'h0; p_n[FN] = a_n[7]; end
			OP_BIT: begin
				p_n[FZ] = (a_q & m) == 8'h0;
				p_n[FV] = m[6];
				p_n[FN] = m[7];
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				t = (op == OP_CMP) ? a_q : (op == OP_CPX) ? x_q : y_q;
				cmpv = {1'b0, t} - {1'b0, m};
				p_n[FN] = cmpv[7];
				p_n[FC] = ~cmpv[8];
				p_n[FZ] = t == m;
			end
			OP_ASL: begin rr = {src[6:0], 1'b0}; p_n[FC] = src[7]; rmw = 1'b1; end
			OP_LSR: begin rr = {1'b0, src[7:1]}; p_n[FC] = src[0]; rmw = 1'b1; end
			OP_ROL: begin rr = {src[6:0], c}; p_n[FC] = src[7]; rmw = 1'b1; end
			OP_ROR: begin rr = {c, src[7:1]}; p_n[FC] = src[0]; rmw = 1'b1; end
			OP_INC: begin rr = src + 8'd1; rmw = 1'b1; end
			OP_DEC: begin rr = src - 8'd1; rmw = 1'b1; end
			OP_INX: begin x_n = x_q + 8'd1; p_n[FZ] = x_n == 8'h0; p_n[FN] = x_n[7]; end
			OP_INY: begin y_n = y_q + 8'd1; p_n[FZ] = y_n == 8'h0; p_n[FN] = y_n[7]; end
			OP_DEX: begin x_n = x_q - 8'd1; p_n[FZ] = x_n == 8'h0; p_n[FN] = x_n[7]; end
			OP_DEY: begin y_n = y_q - 8'd1; p_n[FZ] = y_n == 8'h0; p_n[FN] = y_n[7]; end
			OP_LDA: begin a_n = m; p_n[FZ] = m == 8'h0; p_n[FN] = m[7]; end
			OP_LDX: begin x_n = m; p_n[FZ] = m == 8'h0; p_n[FN] = m[7]; end
			OP_LDY: begin y_n = m; p_n[FZ] = m == 8'h0; p_n[FN] = m[7]; end
			OP_STA, OP_STX, OP_STY: begin
				r_n.write_kind = WK_MEM;
				r_n.write_address = cls.req.target_address;
				r_n.write_data = (op == OP_STA) ? a_q : (op == OP_STX) ? x_q : y_q;
			end
			OP_TAX: begin x_n = a_q; p_n[FZ] = a_q == 8'h0; p_n[FN] = a_q[7]; end
			OP_TAY: begin y_n = a_q; p_n[FZ] = a_q == 8'h0; p_n[FN] = a_q[7]; end
			OP_TSX: begin x_n = sp_q; p_n[FZ] = sp_q == 8'h0; p_n[FN] = sp_q[7]; end
			OP_TXA: begin a_n = x_q; p_n[FZ] = x_q == 8'h0; p_n[FN] = x_q[7]; end
			OP_TXS: sp_n = x_q;
			OP_TYA: begin a_n = y_q; p_n[FZ] = y_q == 8'h0; p_n[FN] = y_q[7]; end
			OP_CLC: p_n[FC] = 1'b0;
			OP_CLD: p_n[FD] = 1'b0;
			OP_CLI: p_n[FI] = 1'b0;
			OP_CLV: p_n[FV] = 1'b0;
			OP_SEC: p_n[FC] = 1'b1;
			OP_SED: p_n[FD] = 1'b1;
			OP_SEI: p_n[FI] = 1'b1;
			OP_PHA, OP_PHP: begin
				r_n.write_kind = WK_PUSH;
				r_n.write_address = STACK_BASE | {8'h0, sp_q};
				r_n.write_data = (op == OP_PHA) ? a_q : (p_q | 8'h30);
				sp_n = sp_q - 8'd1;
			end
			OP_PLA: begin
				sp_n = sp_q + 8'd1;
				a_n = m; p_n[FZ] = m == 8'h0; p_n[FN] = m[7];
			end
			OP_PLP: begin sp_n = sp_q + 8'd1; p_n = m; end
			default: begin
				if (cls.is_branch) begin
					case (cls.br_flag)
						2'd0: flag = p_q[FC];
						2'd1: flag = p_q[FZ];
						2'd2: flag = p_q[FN];
						default: flag = p_q[FV];
					endcase
					r_n.branch_target = cls.br_target;
					if (flag == cls.br_want) begin
						r_n.branch_taken = 1'b1;
						r_n.extra_cycles = cls.br_cross ? 2'd2 : 2'd1;
					end
				end
			end
		endcase
		if (rmw) begin
			p_n[FZ] = rr == 8'h0;
			p_n[FN] = rr[7];
			if (cls.req.to_accumulator) a_n = rr;
			else begin
				r_n.write_kind = WK_MEM;
				r_n.write_address = cls.req.target_address;
				r_n.write_data = rr;
			end
		end
		p_n[FU] = 1'b1;
		p_n[FB] = 1'b0;
		r_n.acc_out = a_n;
		r_n.x_out = x_n;
		r_n.y_out = y_n;
		r_n.sp_out = sp_n;
		r_n.status_out = p_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'h0;
			x_q <= 8'h0;
			y_q <= 8'h0;
			sp_q <= SP_RESET;
			p_q <= P_RESET;
		end else if (go) begin
			a_q <= a_n;
			x_q <= x_n;
			y_q <= y_n;
			sp_q <= sp_n;
			p_q <= p_n;
		end
	end

	always_ff @(posedge clk) begin
		if (go) res_q <= r_n;
	end

endmodule

FILE: design/cpu6502_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu6502_execute_unit: 6502 ALU and register execute
// A request is registered in the queue and then in the result register before it is output.
// Throughput: one request per cycle while the result channel is ready.
// A two-entry queue sits between classification and execution.
// Reset: A, X, Y cleared, SP to 0xFD, status to 0x20, queue and result empty.
// ----------------------------------------------------------------------------
module cpu6502_execute_unit (
	input  logic clk,
	input  logic arst_n,
	c6502_req_if.sink   in_ch,
	c6502_res_if.source out_ch
);
	import c6502_pkg::*;

	cls_t cls_in, cls_out;
	logic full, empty, pop, out_v_q;

	c6502_front u_front (.req(in_ch.data), .cls(cls_in));

	assign in_ch.ready = ~full;
	assign pop = ~empty & (~out_v_q | out_ch.ready);

	c6502_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(in_ch.valid & ~full), .din(cls_in), .full(full),
		.pop(pop), .empty(empty), .dout(cls_out)
	);

	c6502_back u_back (
		.clk(clk), .arst_n(arst_n), .go(pop), .cls(cls_out), .res(out_ch.data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (pop) out_v_q <= 1'b1;
		else if (out_ch.ready) out_v_q <= 1'b0;
	end

	assign out_ch.valid = out_v_q;

endmodule
